### hdl/lpc_pkg.sv
// shared types, constants and aes helper functions for the payload cipher
`timescale 1ns / 1ps

package lpc_pkg;

    localparam int LPC_QUEUE_DEPTH = 4;
    localparam int LPC_OUT_DEPTH   = 2;
    localparam int LPC_KEY_W       = 64;
    localparam int LPC_ADDR_W      = 4;
    localparam logic [7:0] LPC_A_FLAG   = 8'h01;
    localparam logic [3:0] LPC_LAST_RND = 4'd10;
    localparam logic [3:0] LPC_LAST_POS = 4'd15;

    // register map, selected by paddr bit 3
    typedef enum logic {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } lpc_reg_t;

    // what selects one keystream block
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] cnt;
        logic        dir;
        logic [7:0]  idx;
    } lpc_blk_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       refresh;
        logic [3:0] pos;
        lpc_blk_t   blk;
    } lpc_item_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        unique case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // next round key from the current one, byte 0 in the top bits
    function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = rk[127:96];
        w1 = rk[95:64];
        w2 = rk[63:32];
        w3 = rk[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // subbytes, shiftrows, mixcolumns (skipped in the last round), addroundkey
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int k = 0; k < 16; k++)
            b[k] = s[127 - 8*k -: 8];
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[i + 4*c] = SBOX[b[i + 4*((c + i) % 4)]];
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4*c];
                a1 = t[4*c+1];
                a2 = t[4*c+2];
                a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int k = 0; k < 16; k++)
            r[127 - 8*k -: 8] = t[k];
        return r ^ rk;
    endfunction

    function automatic logic [127:0] a_block(input lpc_blk_t blk);
        return {LPC_A_FLAG, 32'h0, 7'h0, blk.dir,
                blk.addr[7:0], blk.addr[15:8], blk.addr[23:16], blk.addr[31:24],
                blk.cnt[7:0], blk.cnt[15:8], blk.cnt[23:16], blk.cnt[31:24],
                8'h00, blk.idx};
    endfunction

endpackage

### hdl/lpc_front.sv
// front end: accepts bytes, tracks frame position and queues classified items
`timescale 1ns / 1ps

module lpc_front
    import lpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = LPC_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [31:0] dev_addr,
    input  logic [31:0] frame_counter,
    input  logic        downlink,
    output logic        head_valid,
    output lpc_item_t   head,
    input  logic        head_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lpc_item_t        q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]       pos_reg, pos_next;
    logic [7:0]       idx_reg, idx_next;
    logic [31:0]      addr_reg, addr_next, fc_reg, fc_next;
    logic             dir_reg, dir_next;
    logic             acc;
    logic [3:0]       cur_pos;
    logic [7:0]       cur_idx;
    lpc_item_t        item;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign acc        = push && !full;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_reg];

    always_comb
    begin
        addr_next = addr_reg;
        fc_next   = fc_reg;
        dir_next  = dir_reg;
        cur_pos   = pos_reg;
        cur_idx   = idx_reg;
        if (first_byte)
        begin
            addr_next = dev_addr;
            fc_next   = frame_counter;
            dir_next  = downlink;
            cur_pos   = 4'd0;
            cur_idx   = 8'd1;
        end
        item.data     = data_byte;
        item.last     = last_byte;
        item.refresh  = (cur_pos == 4'd0);
        item.pos      = cur_pos;
        item.blk.addr = addr_next;
        item.blk.cnt  = fc_next;
        item.blk.dir  = dir_next;
        item.blk.idx  = cur_idx;
        pos_next      = cur_pos + 4'd1;
        idx_next      = cur_idx + {7'd0, (cur_pos == LPC_LAST_POS)};
    end

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (acc)
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (head_pop)
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (acc && !head_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!acc && head_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            cnt_reg  <= '0;
            pos_reg  <= '0;
            idx_reg  <= 8'd1;
            addr_reg <= '0;
            fc_reg   <= '0;
            dir_reg  <= 1'b0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
            if (acc)
            begin
                pos_reg  <= pos_next;
                idx_reg  <= idx_next;
                addr_reg <= addr_next;
                fc_reg   <= fc_next;
                dir_reg  <= dir_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            q_reg[wr_reg] <= item;
    end

endmodule

### hdl/lpc_aes.sv
// iterative aes-128 encryption, one round per cycle with on-the-fly key expansion
`timescale 1ns / 1ps

module lpc_aes
    import lpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [127:0] block_in,
    output logic         busy,
    output logic         done,
    output logic [127:0] block_out
);

    logic [127:0] st_reg, rk_reg, rk_next;
    logic [3:0]   rnd_reg;
    logic         busy_reg;

    assign busy      = busy_reg;
    assign done      = busy_reg && (rnd_reg == LPC_LAST_RND);
    assign rk_next   = key_expand(rk_reg, rcon(rnd_reg));
    assign block_out = aes_round(st_reg, rk_next, rnd_reg == LPC_LAST_RND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 4'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            rnd_reg  <= 4'd1;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            rnd_reg  <= rnd_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            st_reg <= block_in ^ key;
            rk_reg <= key;
        end
        else if (busy_reg)
        begin
            st_reg <= block_out;
            rk_reg <= rk_next;
        end
    end

endmodule

### hdl/lpc_back.sv
// back end: keystream management with look-ahead block and result queue
`timescale 1ns / 1ps

module lpc_back
    import lpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [127:0] key,
    input  logic         cfg_wr,
    input  logic         head_valid,
    input  lpc_item_t    head,
    output logic         head_pop,
    output logic         empty,
    input  logic         pop,
    output logic [7:0]   cipher_byte,
    output logic         frame_end
);

    localparam int OPTR_W = $clog2(LPC_OUT_DEPTH);
    localparam int OCNT_W = $clog2(LPC_OUT_DEPTH + 1);

    logic [127:0]      ks_reg, res_reg;
    lpc_blk_t          res_tag_reg, run_tag_reg, start_tag;
    logic              res_valid_reg, stale_reg;
    logic              eng_start, eng_busy, eng_done, hit;
    logic [127:0]      eng_out, ks_use;
    logic [7:0]        o_data_reg [LPC_OUT_DEPTH];
    logic              o_last_reg [LPC_OUT_DEPTH];
    logic [OPTR_W-1:0] owr_reg, ord_reg;
    logic [OCNT_W-1:0] ocnt_reg;
    logic              out_room, opop;

    lpc_aes u_aes (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eng_start),
        .key       (key),
        .block_in  (a_block(start_tag)),
        .busy      (eng_busy),
        .done      (eng_done),
        .block_out (eng_out)
    );

    assign out_room = (ocnt_reg < OCNT_W'(LPC_OUT_DEPTH));
    assign hit      = res_valid_reg && (res_tag_reg == head.blk);
    assign head_pop = head_valid && out_room && (!head.refresh || hit);
    assign ks_use   = head.refresh ? res_reg : ks_reg;

    // after a block is taken into use, start on the next index right away
    always_comb
    begin
        eng_start = 1'b0;
        start_tag = head.blk;
        if (head_pop && head.refresh)
        begin
            eng_start     = 1'b1;
            start_tag.idx = head.blk.idx + 8'd1;
        end
        else if (head_valid && head.refresh && !hit && !eng_busy)
            eng_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            stale_reg     <= 1'b0;
        end
        else
        begin
            if (eng_start)
                stale_reg <= cfg_wr;
            else if (cfg_wr)
                stale_reg <= 1'b1;
            if (eng_start || cfg_wr)
                res_valid_reg <= 1'b0;
            else if (eng_done)
                res_valid_reg <= !stale_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_start)
            run_tag_reg <= start_tag;
        if (eng_done)
        begin
            res_reg     <= eng_out;
            res_tag_reg <= run_tag_reg;
        end
        if (head_pop && head.refresh)
            ks_reg <= res_reg;
    end

    // result queue
    assign empty       = (ocnt_reg == '0);
    assign opop        = pop && !empty;
    assign cipher_byte = o_data_reg[ord_reg];
    assign frame_end   = o_last_reg[ord_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= '0;
            ord_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            if (head_pop)
                owr_reg <= owr_reg + 1'b1;
            if (opop)
                ord_reg <= ord_reg + 1'b1;
            if (head_pop && !opop)
                ocnt_reg <= ocnt_reg + 1'b1;
            else if (!head_pop && opop)
                ocnt_reg <= ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            o_data_reg[owr_reg] <= head.data ^ ks_use[127 - 8*head.pos -: 8];
            o_last_reg[owr_reg] <= head.last;
        end
    end

endmodule

### hdl/lorawan_payload_cipher.sv
// LoRaWAN frame payload cipher: byte stream XOR with an aes-128 keystream
//
// usage: bytes enter through a queue port (push/full), one per transaction;
// each byte yields exactly one result on the output queue port (empty/pop)
// carrying cipher_byte and frame_end. first_byte latches dev_addr,
// frame_counter and downlink and restarts the block index at 1.
// the key is written through the apb port (key_low at 0x0, key_high at 0x8),
// and the user must do so only while no bytes are in flight; the block itself
// does not enforce this. a byte passes the input and output queue registers
// before it can be popped when the keystream block is ready; the first byte
// of a frame, or of a block whose look-ahead was not usable, also waits for
// the aes unit, and longer when a look-ahead run has to finish first.
// throughput: one byte per cycle sustained while pop keeps up and the
// keystream block is ready; the iterative aes unit starts the next block as
// soon as one is used, so it stays ahead of a 16-byte block.
// reset: queues empty, keys zero, block index 1, byte position 0.
// when pop stays low, results collect in the output queue, then the input
// queue fills and full rises; no transaction is lost.
`timescale 1ns / 1ps

module lorawan_payload_cipher
    import lpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = LPC_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [LPC_ADDR_W-1:0] paddr,
    input  logic [LPC_KEY_W-1:0]  pwdata,
    output logic [LPC_KEY_W-1:0]  prdata,
    output logic                  pready,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            data_byte,
    input  logic                  first_byte,
    input  logic                  last_byte,
    input  logic [31:0]           dev_addr,
    input  logic [31:0]           frame_counter,
    input  logic                  downlink,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            cipher_byte,
    output logic                  frame_end
);

    logic [LPC_KEY_W-1:0] key_low_reg, key_high_reg;
    logic                 cfg_wr;
    lpc_reg_t             sel;
    logic                 head_valid, head_pop;
    lpc_item_t            head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign sel    = lpc_reg_t'(paddr[3]);

    always_comb
    begin
        unique case (sel)
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_KEY_HIGH: prdata = key_high_reg;
            default:      prdata = key_low_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (sel == REG_KEY_HIGH)
                key_high_reg <= pwdata;
            else
                key_low_reg <= pwdata;
        end
    end

    lpc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .last_byte     (last_byte),
        .dev_addr      (dev_addr),
        .frame_counter (frame_counter),
        .downlink      (downlink),
        .head_valid    (head_valid),
        .head          (head),
        .head_pop      (head_pop)
    );

    lpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         ({key_high_reg, key_low_reg}),
        .cfg_wr      (cfg_wr),
        .head_valid  (head_valid),
        .head        (head),
        .head_pop    (head_pop),
        .empty       (empty),
        .pop         (pop),
        .cipher_byte (cipher_byte),
        .frame_end   (frame_end)
    );

endmodule

### hdl/lpc_checker.sv
// port-level checks for the payload cipher, bound to the top level
`timescale 1ns / 1ps

module lpc_checker
    import lpc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [LPC_ADDR_W-1:0] paddr,
    input logic [LPC_KEY_W-1:0]  pwdata,
    input logic [LPC_KEY_W-1:0]  prdata,
    input logic                  pready,
    input logic                  empty,
    input logic                  pop,
    input logic [7:0]            cipher_byte,
    input logic                  frame_end
);

    a_empty_in_reset: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(cipher_byte) && $stable(frame_end)))
        else $error("waiting result changed");

    a_key_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite) |=>
            ((paddr[3] != $past(paddr[3])) || (prdata == $past(pwdata))))
        else $error("key register does not read back written value");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind lorawan_payload_cipher lpc_checker u_lpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .empty       (empty),
    .pop         (pop),
    .cipher_byte (cipher_byte),
    .frame_end   (frame_end)
);
